@@ rtl/core/vsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Vectorscope accumulator package
// Shared constants, operation codes and the word type that the queue carries.
// ----------------------------------------------------------------------------
package vsa_pkg;

	// Grid geometry. The side is a power of two, so a cell address is {row, column}.
	localparam int GRID_SIDE  = 256;
	localparam int GRID_BITS  = $clog2(GRID_SIDE);
	localparam int ADDR_BITS  = 2 * GRID_BITS;
	localparam int CELLS      = GRID_SIDE * GRID_SIDE;

	// Cell counters.
	localparam int COUNT_BITS = 24;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Field widths.
	localparam int SAMPLE_W   = 23;
	localparam int INDEX_W    = 16;
	localparam int OUT_W      = 24;
	localparam int LUMA_W     = 23;
	localparam int DIFF_W     = 24;
	localparam int NORM_W     = 23;
	localparam int PROD_W     = 41;
	localparam int CHROMA_W   = 41;
	localparam int NUM_W      = 42 + GRID_BITS;

	// Luma weights and chroma scales, Q16.
	localparam logic signed [17:0] COEF_R   = 18'sd17216;
	localparam logic signed [17:0] COEF_G   = 18'sd44433;
	localparam logic signed [17:0] COEF_B   = 18'sd3886;
	localparam logic signed [17:0] SCALE_CB = 18'sd32047;
	localparam logic signed [17:0] SCALE_CR = 18'sd40888;
	localparam logic signed [LUMA_W-1:0] LUMA_MIN = LUMA_W'(6);
	localparam logic signed [LUMA_W-1:0] NORM_MIN = LUMA_W'(256);

	// Input mode codes.
	localparam logic [1:0] MODE_ACC   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// Operations handed to the back end.
	typedef enum logic [1:0] {
		OP_ACC,
		OP_READ,
		OP_CLEAR
	} op_t;

	// One queued word.
	typedef struct packed {
		op_t                 op;
		logic [NUM_W-1:0]    num_x;
		logic [NUM_W-1:0]    num_y;
		logic [NORM_W-1:0]   norm;
		logic [INDEX_W-1:0]  cell_index;
	} job_t;

endpackage

@@ rtl/core/vsa_front.sv @@
// ----------------------------------------------------------------------------
// Vectorscope front end
// Accepts one word at a time, works out luma and the two chroma numerators,
// drops skipped or off-grid pixels and unused-mode words, and hands the rest to the queue.
// ----------------------------------------------------------------------------
module vsa_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [1:0]                   mode,
	input  logic [vsa_pkg::SAMPLE_W-1:0] red_sample,
	input  logic [vsa_pkg::SAMPLE_W-1:0] green_sample,
	input  logic [vsa_pkg::SAMPLE_W-1:0] blue_sample,
	input  logic [vsa_pkg::INDEX_W-1:0]  cell_index,
	input  logic                         q_full,
	output logic                         q_push,
	output vsa_pkg::job_t                q_job,
	output logic                         active
);
	import vsa_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [1:0] mode_s1, mode_s2, mode_s3, mode_s4;
	logic [INDEX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [PROD_W-1:0] pr_s1, pg_s1, pb_s1;
	logic signed [SAMPLE_W-1:0] r_s1, b_s1, r_s2, b_s2;
	logic signed [LUMA_W-1:0] luma_s2;
	logic signed [DIFF_W-1:0] db_s3, dr_s3;
	logic [NORM_W-1:0] norm_s3, norm_s4;
	logic skip_s3, skip_s4;
	logic signed [CHROMA_W-1:0] mb_s4, mr_s4;
	logic [NORM_W+GRID_BITS:0] nb_s4;
	logic keep_s5;
	job_t job_s5;

	logic signed [PROD_W:0] luma_sum;
	logic signed [NUM_W-1:0] base_x, term_x, term_y, nx, ny, bound;
	logic off_grid;

	assign active = valid_s1 | valid_s2 | valid_s3 | valid_s4 | valid_s5;
	assign q_push = valid_s5 & keep_s5 & !q_full;
	assign q_job  = job_s5;

	// Stage valids; the last stage holds while the queue is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (valid_s4)
				valid_s5 <= 1'b1;
			else if (!keep_s5 || !q_full)
				valid_s5 <= 1'b0;
		end
	end

	// Weighted products of the three samples.
	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode;
			idx_s1  <= cell_index;
			r_s1    <= red_sample;
			b_s1    <= blue_sample;
			pr_s1   <= PROD_W'(signed'(red_sample)) * PROD_W'(COEF_R);
			pg_s1   <= PROD_W'(signed'(green_sample)) * PROD_W'(COEF_G);
			pb_s1   <= PROD_W'(signed'(blue_sample)) * PROD_W'(COEF_B);
		end
	end

	// Luma is the floor of the weighted sum over 65536.
	assign luma_sum = (PROD_W+1)'(pr_s1) + (PROD_W+1)'(pg_s1) + (PROD_W+1)'(pb_s1);

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		idx_s2  <= idx_s1;
		r_s2    <= r_s1;
		b_s2    <= b_s1;
		luma_s2 <= LUMA_W'(luma_sum >>> 16);
	end

	// Colour differences, the normaliser and the dark-pixel test.
	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		idx_s3  <= idx_s2;
		skip_s3 <= luma_s2 < LUMA_MIN;
		norm_s3 <= NORM_W'((luma_s2 > NORM_MIN) ? luma_s2 : NORM_MIN);
		db_s3   <= DIFF_W'(b_s2) - DIFF_W'(luma_s2);
		dr_s3   <= DIFF_W'(r_s2) - DIFF_W'(luma_s2);
	end

	// Scaled chroma and the grid centre term.
	always_ff @(posedge clk) begin
		mode_s4 <= mode_s3;
		idx_s4  <= idx_s3;
		skip_s4 <= skip_s3;
		norm_s4 <= norm_s3;
		mb_s4   <= CHROMA_W'(db_s3) * CHROMA_W'(SCALE_CB);
		mr_s4   <= CHROMA_W'(dr_s3) * CHROMA_W'(SCALE_CR);
		nb_s4   <= (NORM_W+GRID_BITS+1)'(norm_s3) * (NORM_W+GRID_BITS+1)'(GRID_SIDE + 1);
	end

	// Numerators over the divisor 2^17 * norm; the quotient must land on the grid.
	assign base_x   = signed'(NUM_W'(nb_s4) << 16);
	assign term_x   = NUM_W'(mb_s4) <<< GRID_BITS;
	assign term_y   = NUM_W'(mr_s4) <<< GRID_BITS;
	assign nx       = base_x + term_x;
	assign ny       = base_x - term_y;
	assign bound    = signed'(NUM_W'(norm_s4) << (17 + GRID_BITS));
	assign off_grid = nx < 0 || ny < 0 || nx >= bound || ny >= bound;

	// Classify the word for the back end.
	always_ff @(posedge clk) begin
		if (valid_s4) begin
			job_s5.num_x      <= nx;
			job_s5.num_y      <= ny;
			job_s5.norm       <= norm_s4;
			job_s5.cell_index <= idx_s4;
			unique case (mode_s4)
				MODE_ACC: begin
					job_s5.op <= OP_ACC;
					keep_s5   <= !skip_s4 && !off_grid;
				end
				MODE_READ: begin
					job_s5.op <= OP_READ;
					keep_s5   <= 1'b1;
				end
				MODE_CLEAR: begin
					job_s5.op <= OP_CLEAR;
					keep_s5   <= 1'b1;
				end
				default: begin
					job_s5.op <= OP_ACC;
					keep_s5   <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/vsa_fifo.sv @@
// ----------------------------------------------------------------------------
// Vectorscope job queue
// A four-entry first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module vsa_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vsa_pkg::job_t push_job,
	input  logic          pop,
	output vsa_pkg::job_t pop_job,
	output logic          full,
	output logic          empty
);
	import vsa_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	job_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] fill_q;

	assign full    = fill_q == (PTR_W+1)'(DEPTH);
	assign empty   = fill_q == '0;
	assign pop_job = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

endmodule

@@ rtl/core/vsa_back.sv @@
// ----------------------------------------------------------------------------
// Vectorscope back end
// Divides out the cell position, updates the hit store and the peak, answers
// reads and sweeps the store clear.
// ----------------------------------------------------------------------------
module vsa_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  vsa_pkg::job_t              q_job,
	output logic                       q_pop,
	output logic                       init_busy,
	output logic                       strobe,
	output logic [vsa_pkg::OUT_W-1:0]  cell_count,
	output logic [vsa_pkg::OUT_W-1:0]  peak_count
);
	import vsa_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_DIVX  = 3'd2;
	localparam logic [2:0] ST_DIVY  = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd5;
	localparam logic [2:0] ST_RESP  = 3'd6;

	localparam int STEP_W = $clog2(GRID_BITS);

	logic [2:0] state_q;
	logic init_q;
	logic [ADDR_BITS-1:0] sweep_q;
	job_t job_q;
	logic [NUM_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic [GRID_BITS-1:0] qx_q, qy_q;
	logic [COUNT_BITS-1:0] peak_q;
	logic strobe_q;
	logic [OUT_W-1:0] cell_q, peak_out_q;

	logic [COUNT_BITS-1:0] mem [CELLS];
	logic [COUNT_BITS-1:0] rdata_q;
	logic we, re;
	logic [ADDR_BITS-1:0] waddr, raddr;
	logic [COUNT_BITS-1:0] wdata, bumped;

	logic [NUM_W-1:0] trial;
	logic fits, in_grid;

	assign q_pop      = state_q == ST_IDLE && !q_empty;
	assign init_busy  = init_q;
	assign strobe     = strobe_q;
	assign cell_count = cell_q;
	assign peak_count = peak_out_q;

	// One restoring division step: divisor 2^17 * norm scaled to this bit.
	assign trial = (NUM_W'(job_q.norm) << 17) << step_q;
	assign fits  = rem_q >= trial;

	assign bumped  = (rdata_q == COUNT_MAX) ? rdata_q : rdata_q + 1'b1;
	assign in_grid = {1'b0, job_q.cell_index} < (INDEX_W+1)'(CELLS);

	// Store port controls. The last y step's bit is folded into the fetch address.
	always_comb begin
		we    = 1'b0;
		waddr = sweep_q;
		wdata = '0;
		re    = 1'b0;
		raddr = {qy_q, qx_q};
		unique case (state_q)
			ST_CLEAR: we = 1'b1;
			ST_DIVY: begin
				re    = step_q == '0;
				raddr = {qy_q[GRID_BITS-1:1], fits, qx_q};
			end
			ST_WRITE: begin
				we    = 1'b1;
				waddr = {qy_q, qx_q};
				wdata = bumped;
			end
			ST_IDLE: begin
				re    = q_pop && q_job.op == OP_READ;
				raddr = ADDR_BITS'(q_job.cell_index);
			end
			default: ;
		endcase
	end

	// Hit store.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			init_q     <= 1'b1;
			sweep_q    <= '0;
			peak_q     <= '0;
			strobe_q   <= 1'b0;
			step_q     <= '0;
			job_q      <= '0;
			rem_q      <= '0;
			qx_q       <= '0;
			qy_q       <= '0;
			cell_q     <= '0;
			peak_out_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						job_q <= q_job;
						unique case (q_job.op)
							OP_ACC: begin
								rem_q   <= q_job.num_x;
								step_q  <= STEP_W'(GRID_BITS - 1);
								qx_q    <= '0;
								qy_q    <= '0;
								state_q <= ST_DIVX;
							end
							OP_READ: begin
								init_q  <= 1'b0;
								cell_q  <= '0;
								state_q <= ST_RESP;
							end
							OP_CLEAR: begin
								sweep_q <= '0;
								state_q <= ST_CLEAR;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					peak_q  <= '0;
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == ADDR_BITS'(CELLS - 1)) begin
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_DIVX: begin
					qx_q[step_q] <= fits;
					if (step_q == '0) begin
						rem_q   <= job_q.num_y;
						step_q  <= STEP_W'(GRID_BITS - 1);
						state_q <= ST_DIVY;
					end else begin
						if (fits)
							rem_q <= rem_q - trial;
						step_q <= step_q - 1'b1;
					end
				end
				ST_DIVY: begin
					if (fits)
						rem_q <= rem_q - trial;
					qy_q[step_q] <= fits;
					if (step_q == '0)
						state_q <= ST_WRITE;
					else
						step_q <= step_q - 1'b1;
				end
				ST_WRITE: begin
					if (bumped > peak_q)
						peak_q <= bumped;
					state_q <= ST_IDLE;
				end
				ST_RESP: begin
					strobe_q   <= 1'b1;
					cell_q     <= in_grid ? OUT_W'(rdata_q) : '0;
					peak_out_q <= OUT_W'(peak_q);
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/vectorscope_accumulator.sv @@
// ----------------------------------------------------------------------------
// Vectorscope accumulator
// Builds a Cb/Cr hit grid from linear RGB pixels and answers cell reads.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 65536-cell store clear, one cell a cycle,
// and holds busy high while it does so. A word is taken when start is
// high and busy low; the front end then holds busy while it classifies it,
// so it takes no new word until the last one has left the front end, and a
// four-word queue lets it take the next word while the back end works. An
// accumulated pixel is taken from the queue, then goes through two 8-step
// restoring divisions in one shared divider with the store read folded into
// the last step, then a write of the store; the back end takes no new word
// until that write. A read passes from the queue through a response state and
// then raises strobe, and its word is taken at the edge that ends the strobe
// cycle; strobe is held for exactly one cycle and the receiver cannot stall
// it. A clear word sweeps the store again, and words behind it wait in the
// queue.
module vectorscope_accumulator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [vsa_pkg::SAMPLE_W-1:0] red_sample,
	input  logic [vsa_pkg::SAMPLE_W-1:0] green_sample,
	input  logic [vsa_pkg::SAMPLE_W-1:0] blue_sample,
	input  logic [vsa_pkg::INDEX_W-1:0]  cell_index,
	output logic                         strobe,
	output logic [vsa_pkg::OUT_W-1:0]    cell_count,
	output logic [vsa_pkg::OUT_W-1:0]    peak_count
);
	import vsa_pkg::*;

	logic front_active, init_busy, take;
	logic q_push, q_pop, q_full, q_empty;
	job_t push_job, pop_job;

	// One word in the front end at a time, none during the start-up sweep.
	assign busy = front_active | init_busy;
	assign take = start & !busy;

	vsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.mode         (mode),
		.red_sample   (red_sample),
		.green_sample (green_sample),
		.blue_sample  (blue_sample),
		.cell_index   (cell_index),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (push_job),
		.active       (front_active)
	);

	vsa_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	vsa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (pop_job),
		.q_pop      (q_pop),
		.init_busy  (init_busy),
		.strobe     (strobe),
		.cell_count (cell_count),
		.peak_count (peak_count)
	);

endmodule

@@ tb/sv/vectorscope_accumulator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectorscope accumulator testbench
// Drives pixel, read, clear and unused-mode words into the accumulator. A sparse copy of
// the hit grid in the testbench predicts every read word. Each returned word
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vectorscope_accumulator_test;
	import vsa_pkg::*;

	// The fourth mode code is ignored by the block.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         N_RANDOM    = 830;
	localparam int         CALM_TAIL   = 150;

	typedef struct {
		logic [1:0]          mode;
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
		logic [INDEX_W-1:0]  index;
		bit                  typed;
		logic [OUT_W-1:0]    want_cell;
		logic [OUT_W-1:0]    want_peak;
	} stim_row_t;

	typedef struct {
		logic [OUT_W-1:0] cell_cnt;
		logic [OUT_W-1:0] peak;
	} read_word_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          mode;
	logic [SAMPLE_W-1:0] red_sample;
	logic [SAMPLE_W-1:0] green_sample;
	logic [SAMPLE_W-1:0] blue_sample;
	logic [INDEX_W-1:0]  cell_index;
	logic                strobe;
	logic [OUT_W-1:0]    cell_count;
	logic [OUT_W-1:0]    peak_count;

	// Sparse model of the hit grid and its peak.
	int unsigned       grid_hits[int];
	int unsigned       grid_peak;
	int                touched_cells[$];
	read_word_t        pending_reads[$];
	int                n_errors;

	vectorscope_accumulator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.red_sample   (red_sample),
		.green_sample (green_sample),
		.blue_sample  (blue_sample),
		.cell_index   (cell_index),
		.strobe       (strobe),
		.cell_count   (cell_count),
		.peak_count   (peak_count)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	function automatic longint floor_quot(input longint num, input longint den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	// Luma, normalisation and grid mapping of one pixel, then the count update.
	function automatic void fold_pixel(input logic [SAMPLE_W-1:0] r,
			input logic [SAMPLE_W-1:0] g, input logic [SAMPLE_W-1:0] b);
		longint rs, gs, bs, luma, norm, den, base, px, py;
		int idx;
		int unsigned c;
		rs = longint'($signed(r));
		gs = longint'($signed(g));
		bs = longint'($signed(b));
		luma = floor_quot(17216 * rs + 44433 * gs + 3886 * bs, 65536);
		if (luma < 6)
			return;
		norm = (luma > 256) ? luma : 256;
		den  = 2 * 65536 * norm;
		base = longint'(GRID_SIDE + 1) * 65536 * norm;
		px = floor_quot(base + (bs - luma) * GRID_SIDE * 32047, den);
		py = floor_quot(base - (rs - luma) * GRID_SIDE * 40888, den);
		if (px < 0 || py < 0 || px >= GRID_SIDE || py >= GRID_SIDE)
			return;
		idx = int'(py) * GRID_SIDE + int'(px);
		c = grid_hits.exists(idx) ? grid_hits[idx] : 0;
		if (c == 0)
			touched_cells = {touched_cells, idx};
		if (c < int'(COUNT_MAX))
			c++;
		grid_hits[idx] = c;
		if (c > grid_peak)
			grid_peak = c;
	endfunction

	// Applies one accepted word to the model and returns whether it reads.
	function automatic bit apply_word(input stim_row_t w, output read_word_t rd);
		rd.cell_cnt = '0;
		rd.peak = '0;
		case (w.mode)
			MODE_ACC: begin
				fold_pixel(w.red, w.green, w.blue);
			end
			MODE_READ: begin
				rd.cell_cnt = grid_hits.exists(int'(w.index)) ?
					OUT_W'(grid_hits[int'(w.index)]) : '0;
				rd.peak = OUT_W'(grid_peak);
				return 1'b1;
			end
			MODE_CLEAR: begin
				grid_hits.delete();
				touched_cells.delete();
				grid_peak = 0;
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	// Presents one word and holds it until the block takes it.
	task automatic send_word(input stim_row_t w, input bit allow_gap);
		read_word_t rd;
		int gap;
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		mode         <= w.mode;
		red_sample   <= w.red;
		green_sample <= w.green;
		blue_sample  <= w.blue;
		cell_index   <= w.index;
		do @(posedge clk); while (busy);
		if (apply_word(w, rd)) begin
			if (w.typed && (rd.cell_cnt !== w.want_cell || rd.peak !== w.want_peak))
				report_mismatch("typed expectation", rd.cell_cnt, w.want_cell);
			pending_reads = {pending_reads, rd};
		end
	endtask

	function automatic stim_row_t make_row(input logic [1:0] m, input int r, input int g,
			input int b, input int idx);
		stim_row_t w;
		w.mode  = m;
		w.red   = SAMPLE_W'(r);
		w.green = SAMPLE_W'(g);
		w.blue  = SAMPLE_W'(b);
		w.index = INDEX_W'(idx);
		w.typed = 1'b0;
		w.want_cell = '0;
		w.want_peak = '0;
		return w;
	endfunction

	function automatic stim_row_t make_typed(input int idx, input int c, input int p);
		stim_row_t w;
		w = make_row(MODE_READ, 0, 0, 0, idx);
		w.typed = 1'b1;
		w.want_cell = OUT_W'(c);
		w.want_peak = OUT_W'(p);
		return w;
	endfunction

	// Well-formed pixels sit near grey so that they land on the grid.
	function automatic stim_row_t random_pixel();
		int v, d;
		if ($urandom_range(0, 9) == 0)
			return make_row(MODE_ACC, int'($urandom()), int'($urandom()), int'($urandom()), 0);
		v = (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 600))
			: int'($urandom_range(0, 200000)));
		d = v / 3 + 8;
		return make_row(MODE_ACC, v + int'($urandom_range(0, 2 * d)) - d,
			v + int'($urandom_range(0, 2 * d)) - d, v + int'($urandom_range(0, 2 * d)) - d, 0);
	endfunction

	function automatic stim_row_t random_word(input int n);
		int pick, idx;
		if (n == 280 || n == 560)
			return make_row(MODE_CLEAR, int'($urandom()), int'($urandom()), int'($urandom()),
				int'($urandom()));
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return random_pixel();
		if (pick < 95) begin
			if (touched_cells.size() > 0 && $urandom_range(0, 9) < 6)
				idx = touched_cells[$urandom_range(0, touched_cells.size() - 1)];
			else
				idx = int'($urandom_range(0, 65535));
			return make_row(MODE_READ, int'($urandom()), 0, 0, idx);
		end
		return make_row(MODE_UNUSED, int'($urandom()), int'($urandom()), int'($urandom()),
			int'($urandom()));
	endfunction

	// Returned words against the oldest prediction.
	always @(posedge clk) begin
		read_word_t want;
		if (arst_n && strobe) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("unexpected word", cell_count, '0);
			end else begin
				want = pending_reads.pop_front();
				if (cell_count !== want.cell_cnt)
					report_mismatch("cell_count", cell_count, want.cell_cnt);
				if (peak_count !== want.peak)
					report_mismatch("peak_count", peak_count, want.peak);
			end
		end
	end

	initial begin
		stim_row_t directed[$];
		int n;
		n_errors = 0;
		grid_peak = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		mode <= MODE_ACC;
		red_sample <= '0;
		green_sample <= '0;
		blue_sample <= '0;
		cell_index <= '0;

		// Reset state, extremes, dim and negative pixels, the ignored mode and a clear.
		directed = {directed, make_typed(0, 0, 0)};
		directed = {directed, make_typed(65535, 0, 0)};
		directed = {directed, make_row(MODE_ACC, 25600, 25600, 25600, 0)};
		directed = {directed, make_row(MODE_ACC, 25600, 25600, 25600, 0)};
		directed = {directed, make_row(MODE_ACC, 200, 200, 200, 0)};
		directed = {directed, make_row(MODE_ACC, 5, 5, 5, 0)};
		directed = {directed, make_row(MODE_ACC, 0, 0, 0, 0)};
		directed = {directed, make_row(MODE_ACC, -2560000, -2560000, -2560000, 0)};
		directed = {directed, make_row(MODE_ACC, 2560000, 2560000, 2560000, 0)};
		directed = {directed, make_row(MODE_ACC, 2560000, 0, 0, 0)};
		directed = {directed, make_row(MODE_ACC, 0, 0, 2560000, 0)};
		directed = {directed, make_row(MODE_ACC, 4194303, 4194303, 4194303, 0)};
		directed = {directed, make_row(MODE_ACC, -4194304, -4194304, -4194304, 0)};
		directed = {directed, make_row(MODE_ACC, 30000, 20000, 10000, 0)};
		directed = {directed, make_row(MODE_ACC, 300, 256, 600, 0)};
		directed = {directed, make_row(MODE_READ, 0, 0, 0, 128 * GRID_SIDE + 128)};
		directed = {directed, make_row(MODE_READ, 0, 0, 0, 65535)};
		directed = {directed, make_row(MODE_UNUSED, -1, -1, -1, 65535)};
		directed = {directed, make_row(MODE_READ, 0, 0, 0, 128 * GRID_SIDE + 128)};
		directed = {directed, make_row(MODE_CLEAR, 0, 0, 0, 0)};
		directed = {directed, make_typed(128 * GRID_SIDE + 128, 0, 0)};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_word(directed[i], 1'b1);

		// Let everything drain once before the random part.
		start <= 1'b0;
		while (pending_reads.size() > 0)
			@(posedge clk);

		for (n = 0; n < N_RANDOM; n++)
			send_word(random_word(n), n < N_RANDOM - CALM_TAIL);

		start <= 1'b0;
		while (pending_reads.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/vsa_pkg.sv
rtl/core/vsa_front.sv
rtl/core/vsa_fifo.sv
rtl/core/vsa_back.sv
rtl/core/vectorscope_accumulator.sv
tb/sv/vectorscope_accumulator_test.sv
